// ===== design/ccbt_pkg.sv =====
package ccbt_pkg;

	// Number of parameter targets, one table entry each.
	localparam int NUM_TARGETS = 10;
	localparam int IDX_W       = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

	// Field widths.
	localparam int ACT_W  = 2;
	localparam int CTRL_W = 7;
	localparam int CHAN_W = 6;
	localparam int TGT_W  = 4;

	// Stream data width, padded to whole bytes.
	localparam int TDATA_W = 24;

	// Channel value reported when there is no hit.
	localparam logic [CHAN_W-1:0] CHAN_NONE = '1;

	typedef enum logic [ACT_W-1:0] {
		ACT_BIND  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_FIND  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_REPLY
	} state_t;

	// One table entry as seen on the read port.
	typedef struct packed {
		logic              valid;
		logic [CTRL_W-1:0] ctrl;
		logic [CHAN_W-1:0] chan;
	} entry_t;

	// Write command to the table: set_valid 1 stores a binding, 0 drops it.
	typedef struct packed {
		logic              wr_en;
		logic              set_valid;
		logic [IDX_W-1:0]  addr;
		logic [CTRL_W-1:0] ctrl;
		logic [CHAN_W-1:0] chan;
	} store_wr_t;

endpackage

// ===== design/control_code_binding_table.sv =====
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: action; tdata: ctrl_number, midi_channel, param_target
// m_axis    out  tuser: found;  tdata: target_out, ctrl_out, channel_out
//
// One entry is compared per cycle by a single controller comparator.
// Bind and find walk the whole table; a find hit ends the walk early at its
// entry, and a bind then stores its entry in the commit state. Clear and query
// pass through the commit state alone; a bind or clear to a target out of range
// goes straight to the reply state, which a stalled result holds. The input is
// ready again in the cycle after the result is loaded. Reset empties the table.
module control_code_binding_table import ccbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // ctrl_number, midi_channel, param_target
	input  logic [ACT_W-1:0]   s_axis_tuser,  // action
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // target_out, ctrl_out, channel_out
	output logic               m_axis_tuser   // found
);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	action_t           act_q;
	logic [CTRL_W-1:0] ctrl_q;
	logic [CHAN_W-1:0] chan_q;
	logic [TGT_W-1:0]  tgt_q;
	logic              tgt_ok_q;

	logic              res_found_q;
	logic [TGT_W-1:0]  res_tgt_q;
	logic [CTRL_W-1:0] res_ctrl_q;
	logic [CHAN_W-1:0] res_chan_q;

	logic              out_valid_q;
	logic              out_found_q;
	logic [TGT_W-1:0]  out_tgt_q;
	logic [CTRL_W-1:0] out_ctrl_q;
	logic [CHAN_W-1:0] out_chan_q;

	action_t           in_act;
	logic [CTRL_W-1:0] in_ctrl;
	logic [CHAN_W-1:0] in_chan;
	logic [TGT_W-1:0]  in_tgt;
	logic              in_tgt_ok;
	logic              in_xfer;
	logic              out_free;
	logic              out_load;
	logic              idx_last;
	logic              hit;
	store_wr_t         wr;
	logic [IDX_W-1:0]  rd_addr;
	entry_t            rd_entry;

	// Unpack the input transfer.
	assign in_act    = action_t'(s_axis_tuser);
	assign in_ctrl   = s_axis_tdata[CTRL_W-1:0];
	assign in_chan   = s_axis_tdata[CTRL_W+CHAN_W-1:CTRL_W];
	assign in_tgt    = s_axis_tdata[CTRL_W+CHAN_W+TGT_W-1:CTRL_W+CHAN_W];
	assign in_tgt_ok = (32'(in_tgt) < NUM_TARGETS);
	assign in_xfer   = s_axis_tvalid && s_axis_tready;

	assign idx_last  = (idx_q == IDX_W'(NUM_TARGETS - 1));
	assign out_free  = !out_valid_q || m_axis_tready;

	ccbt_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	ccbt_match u_match (
		.entry (rd_entry),
		.key   (ctrl_q),
		.hit   (hit)
	);

	// Sequencer: next state, table access and handshake.
	always_comb begin
		state_d       = state_q;
		wr            = '0;
		rd_addr       = (state_q == ST_SCAN) ? idx_q : IDX_W'(tgt_q);
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					unique case (in_act)
						ACT_BIND:  state_d = in_tgt_ok ? ST_SCAN : ST_REPLY;
						ACT_CLEAR: state_d = in_tgt_ok ? ST_COMMIT : ST_REPLY;
						ACT_FIND:  state_d = ST_SCAN;
						ACT_QUERY: state_d = ST_COMMIT;
					endcase
				end
			end
			ST_SCAN: begin
				// A bind drops every other entry that uses its controller.
				if (act_q == ACT_BIND && hit) begin
					wr.wr_en     = 1'b1;
					wr.set_valid = 1'b0;
					wr.addr      = idx_q;
				end
				if (act_q == ACT_FIND && hit) begin
					state_d = ST_REPLY;
				end else if (idx_last) begin
					state_d = (act_q == ACT_BIND) ? ST_COMMIT : ST_REPLY;
				end
			end
			ST_COMMIT: begin
				// Store or drop the target's entry; a query only reads it.
				if (act_q == ACT_BIND || act_q == ACT_CLEAR) begin
					wr.wr_en     = 1'b1;
					wr.set_valid = (act_q == ACT_BIND);
					wr.addr      = IDX_W'(tgt_q);
					wr.ctrl      = ctrl_q;
					wr.chan      = chan_q;
				end
				state_d = ST_REPLY;
			end
			ST_REPLY: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				idx_q <= '0;
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item fields and the result under construction.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q       <= in_act;
			ctrl_q      <= in_ctrl;
			chan_q      <= in_chan;
			tgt_q       <= in_tgt;
			tgt_ok_q    <= in_tgt_ok;
			res_found_q <= 1'b0;
			res_tgt_q   <= '0;
			res_ctrl_q  <= '0;
			res_chan_q  <= CHAN_NONE;
		end else begin
			if (state_q == ST_SCAN && act_q == ACT_FIND && hit) begin
				res_found_q <= 1'b1;
				res_tgt_q   <= TGT_W'(idx_q);
			end
			if (state_q == ST_COMMIT && act_q == ACT_QUERY && tgt_ok_q && rd_entry.valid) begin
				res_found_q <= 1'b1;
				res_ctrl_q  <= rd_entry.ctrl;
				res_chan_q  <= rd_entry.chan;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= res_found_q;
			out_tgt_q   <= res_tgt_q;
			out_ctrl_q  <= res_ctrl_q;
			out_chan_q  <= res_chan_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {(TDATA_W - TGT_W - CTRL_W - CHAN_W)'(0),
		out_chan_q, out_ctrl_q, out_tgt_q};

endmodule

// ===== design/ccbt_store.sv =====
module ccbt_store import ccbt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  store_wr_t        wr,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_entry
);

	logic [NUM_TARGETS-1:0] valid_q;
	logic [CTRL_W-1:0]      ctrl_q [NUM_TARGETS];
	logic [CHAN_W-1:0]      chan_q [NUM_TARGETS];

	// Valid bits start cleared so the table is empty after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.wr_en) begin
			valid_q[wr.addr] <= wr.set_valid;
		end
	end

	// Controller and channel are only written by a bind.
	always_ff @(posedge clk) begin
		if (wr.wr_en && wr.set_valid) begin
			ctrl_q[wr.addr] <= wr.ctrl;
			chan_q[wr.addr] <= wr.chan;
		end
	end

	// Single read port; an address past the last target reads as empty.
	always_comb begin
		rd_entry = '0;
		if (32'(rd_addr) < NUM_TARGETS) begin
			rd_entry.valid = valid_q[rd_addr];
			rd_entry.ctrl  = ctrl_q[rd_addr];
			rd_entry.chan  = chan_q[rd_addr];
		end
	end

endmodule

// ===== design/ccbt_match.sv =====
module ccbt_match import ccbt_pkg::*; (
	input  entry_t            entry,
	input  logic [CTRL_W-1:0] key,
	output logic              hit
);

	// Shared compare unit: a live entry bound to the requested controller.
	assign hit = entry.valid && (entry.ctrl == key);

endmodule

// ===== design/ccbt_checker.sv =====
module ccbt_checker import ccbt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic               m_axis_tuser
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

	// A result without a hit carries the fixed miss values.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			m_axis_tdata[16:11] == 6'h3f && m_axis_tdata[10:4] == 7'd0 &&
			m_axis_tdata[3:0] == 4'd0)
		else $error("miss result carries data");

	// A hit is either a find (no controller, no channel) or a query (target 0).
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[3:0] == 4'd0 ||
			(m_axis_tdata[10:4] == 7'd0 && m_axis_tdata[16:11] == 6'h3f))
		else $error("hit result mixes find and query fields");

endmodule

bind control_code_binding_table ccbt_checker u_ccbt_checker (.*);

// ===== dv/tb.sv =====
module tb;
	import ccbt_pkg::*;

	// One reply as the block reports it.
	typedef struct packed {
		logic              found;
		logic [TGT_W-1:0]  target;
		logic [CTRL_W-1:0] ctrl;
		logic [CHAN_W-1:0] chan;
	} reply_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;   // ctrl_number, midi_channel, param_target
	logic [ACT_W-1:0]   s_axis_tuser;   // action
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;   // target_out, ctrl_out, channel_out
	logic               m_axis_tuser;   // found

	// Shadow copy of the binding table.
	logic              bound_valid [NUM_TARGETS];
	logic [CTRL_W-1:0] bound_ctrl  [NUM_TARGETS];
	logic [CHAN_W-1:0] bound_chan  [NUM_TARGETS];

	reply_t            expected_replies[$];
	int                error_count;
	bit                steady;
	int                rx_hold;
	logic [CTRL_W-1:0] ctrl_pool [6];

	control_code_binding_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock with a period of 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Apply one command to the shadow table and work out its reply.
	function automatic reply_t apply_command(action_t act, logic [CTRL_W-1:0] ctrl,
			logic [CHAN_W-1:0] chan, logic [TGT_W-1:0] tgt);
		reply_t rep;
		bit     tgt_ok;
		rep    = '{found: 1'b0, target: '0, ctrl: '0, chan: CHAN_NONE};
		tgt_ok = (tgt < NUM_TARGETS);
		case (act)
			ACT_BIND: begin
				if (tgt_ok) begin
					// Controllers stay unique: drop any other binding of this one.
					for (int i = 0; i < NUM_TARGETS; i++) begin
						if (bound_valid[i] && bound_ctrl[i] == ctrl)
							bound_valid[i] = 1'b0;
					end
					bound_valid[tgt] = 1'b1;
					bound_ctrl[tgt]  = ctrl;
					bound_chan[tgt]  = chan;
				end
			end
			ACT_CLEAR: begin
				if (tgt_ok)
					bound_valid[tgt] = 1'b0;
			end
			ACT_FIND: begin
				for (int i = NUM_TARGETS - 1; i >= 0; i--) begin
					if (bound_valid[i] && bound_ctrl[i] == ctrl) begin
						rep.found  = 1'b1;
						rep.target = i[TGT_W-1:0];
					end
				end
			end
			default: begin
				if (tgt_ok && bound_valid[tgt]) begin
					rep.found = 1'b1;
					rep.ctrl  = bound_ctrl[tgt];
					rep.chan  = bound_chan[tgt];
				end
			end
		endcase
		return rep;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Send one command; called and returning at a falling edge.
	task automatic send_command(action_t act, logic [CTRL_W-1:0] ctrl,
			logic [CHAN_W-1:0] chan, logic [TGT_W-1:0] tgt);
		int     gap;
		reply_t rep;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tuser  = act;
		s_axis_tdata  = {{(TDATA_W - CTRL_W - CHAN_W - TGT_W){1'b0}}, tgt, chan, ctrl};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		rep = apply_command(act, ctrl, chan, tgt);
		expected_replies = {expected_replies, rep};
		@(negedge clk);
	endtask

	task automatic wait_replies_done();
		s_axis_tvalid = 1'b0;
		while (expected_replies.size() != 0)
			@(negedge clk);
	endtask

	// Channel in its legal range -1 to 16.
	function automatic logic [CHAN_W-1:0] rand_chan();
		int c;
		c = int'($urandom_range(0, 17)) - 1;
		return c[CHAN_W-1:0];
	endfunction

	// Receiver side: random stalls, none while steady.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold       <= 0;
		end else if (steady) begin
			m_axis_tready <= 1'b1;
			rx_hold       <= 0;
		end else if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold       <= rx_hold - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			rx_hold       <= pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each transferred reply with the oldest expectation.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("unexpected reply, tdata", int'(m_axis_tdata), 0);
			end else begin
				want = expected_replies.pop_front();
				if (m_axis_tuser !== want.found)
					report_mismatch("found", int'(m_axis_tuser), int'(want.found));
				if (m_axis_tdata[TGT_W-1:0] !== want.target)
					report_mismatch("target_out", int'(m_axis_tdata[TGT_W-1:0]),
						int'(want.target));
				if (m_axis_tdata[TGT_W +: CTRL_W] !== want.ctrl)
					report_mismatch("ctrl_out", int'(m_axis_tdata[TGT_W +: CTRL_W]),
						int'(want.ctrl));
				if (m_axis_tdata[TGT_W + CTRL_W +: CHAN_W] !== want.chan)
					report_mismatch("channel_out",
						int'($signed(m_axis_tdata[TGT_W + CTRL_W +: CHAN_W])),
						int'($signed(want.chan)));
				if (m_axis_tdata[TDATA_W-1:TGT_W + CTRL_W + CHAN_W] !== '0)
					report_mismatch("tdata padding",
						int'(m_axis_tdata[TDATA_W-1:TGT_W + CTRL_W + CHAN_W]), 0);
			end
		end
	end

	// Lookups on an empty table and bindings at the field extremes.
	task automatic test_extremes();
		send_command(ACT_QUERY, 7'd0, 6'd0, 4'd0);
		send_command(ACT_FIND, 7'd0, 6'd0, 4'd0);
		send_command(ACT_BIND, 7'd0, 6'h3F, 4'd0);
		send_command(ACT_BIND, 7'd127, 6'd16, 4'd9);
		send_command(ACT_QUERY, 7'd0, 6'd0, 4'd0);
		send_command(ACT_QUERY, 7'd0, 6'd0, 4'd9);
		send_command(ACT_FIND, 7'd0, 6'd0, 4'd0);
		send_command(ACT_FIND, 7'd127, 6'd0, 4'd0);
		send_command(ACT_FIND, 7'd85, 6'd0, 4'd0);
	endtask

	// A bind steals the controller from another target or replaces a binding.
	task automatic test_rebinding();
		send_command(ACT_BIND, 7'd127, 6'd5, 4'd3);
		send_command(ACT_QUERY, 7'd0, 6'd0, 4'd9);
		send_command(ACT_FIND, 7'd127, 6'd0, 4'd0);
		send_command(ACT_BIND, 7'd42, 6'd10, 4'd3);
		send_command(ACT_FIND, 7'd127, 6'd0, 4'd0);
		send_command(ACT_QUERY, 7'd0, 6'd0, 4'd3);
		send_command(ACT_CLEAR, 7'd42, 6'd0, 4'd3);
		send_command(ACT_QUERY, 7'd0, 6'd0, 4'd3);
		send_command(ACT_FIND, 7'd42, 6'd0, 4'd0);
	endtask

	// Targets out of range leave the table untouched.
	task automatic test_bad_target();
		send_command(ACT_BIND, 7'd0, 6'd7, 4'd10);
		send_command(ACT_BIND, 7'd0, 6'd7, 4'd15);
		send_command(ACT_FIND, 7'd0, 6'd0, 4'd0);
		send_command(ACT_QUERY, 7'd0, 6'd0, 4'd15);
		send_command(ACT_CLEAR, 7'd0, 6'd0, 4'd12);
		send_command(ACT_QUERY, 7'd0, 6'd0, 4'd0);
		send_command(ACT_CLEAR, 7'd0, 6'd0, 4'd0);
	endtask

	// Random commands, mostly on a few controllers so that lookups hit.
	task automatic test_random_traffic(int count);
		action_t           act;
		logic [CTRL_W-1:0] ctrl;
		logic [TGT_W-1:0]  tgt;
		int                r;
		for (int k = 0; k < 6; k++)
			ctrl_pool[k] = CTRL_W'($urandom_range(0, 127));
		for (int i = 0; i < count; i++) begin
			// Stretches without any stall, and a full drain now and then.
			if (i % 250 == 100)
				steady = 1'b1;
			if (i % 250 == 140)
				steady = 1'b0;
			if (i % 300 == 299)
				wait_replies_done();
			r = $urandom_range(0, 99);
			if (r < 35)
				act = ACT_BIND;
			else if (r < 45)
				act = ACT_CLEAR;
			else if (r < 75)
				act = ACT_FIND;
			else
				act = ACT_QUERY;
			if ($urandom_range(0, 9) < 7)
				ctrl = ctrl_pool[$urandom_range(0, 5)];
			else
				ctrl = CTRL_W'($urandom_range(0, 127));
			if ($urandom_range(0, 99) < 88)
				tgt = TGT_W'($urandom_range(0, NUM_TARGETS - 1));
			else
				tgt = TGT_W'($urandom_range(NUM_TARGETS, 15));
			send_command(act, ctrl, rand_chan(), tgt);
		end
	endtask

	// Overall run limit.
	initial begin
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		error_count   = 0;
		steady        = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_BIND;
		for (int i = 0; i < NUM_TARGETS; i++) begin
			bound_valid[i] = 1'b0;
			bound_ctrl[i]  = '0;
			bound_chan[i]  = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_rebinding();
		wait_replies_done();
		test_bad_target();
		test_random_traffic(1150);

		// Drain and let the block settle.
		wait_replies_done();
		repeat (2 * NUM_TARGETS + 8) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
